/* hdl/dfs1d_pkg.sv */
// Shared types and constants of the 1-D explicit diffusion step block.
// Holds field widths, action codes, register indexes, controller states and the
// command, status and configuration structs. Depends on nothing.
`default_nettype none

package dfs1d_pkg;

  localparam int VAL_W         = 32;
  localparam int IDX_W         = 10;
  localparam int NUM_W         = 11;
  localparam int RAT_W         = 16;
  localparam int CFG_AW        = 5;
  localparam int CFG_DW        = 32;
  localparam int DEF_MAX_NODES = 1024;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    ACT_LOAD = 2'd0,
    ACT_READ = 2'd1,
    ACT_STEP = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    REG_NUM_NODES   = 3'd0,
    REG_DIFF_RATIO  = 3'd1,
    REG_STEP_TIME   = 3'd2,
    REG_FIXED_MODE  = 3'd3,
    REG_FIXED_NODE  = 3'd4,
    REG_FIXED_VALUE = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_RD_IDX,
    ST_RD_OUT,
    ST_SETUP,
    ST_RD_C,
    ST_RD_R,
    ST_LAP,
    ST_MUL_LAP,
    ST_MUL_SRC,
    ST_SUM,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [NUM_W-1:0]        num_nodes;
    logic [RAT_W-1:0]        diff_ratio;
    logic [RAT_W-1:0]        step_time;
    logic                    fixed_mode;
    logic [IDX_W-1:0]        fixed_node;
    logic signed [VAL_W-1:0] fixed_value;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic clr_wr;
    logic load_wr;
    logic rd_idx;
    logic emit_read;
    logic setup;
    logic rd_c;
    logic rd_r;
    logic lap;
    logic mul_lap;
    logic mul_src;
    logic sum;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic clr_done;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/dfs1d_ifs.sv */
// Valid/ready channel interfaces for the input items and the result items.
// Depends on dfs1d_pkg for the field widths.
`default_nettype none

interface dfs1d_in_if import dfs1d_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              action;
  logic [IDX_W-1:0]        node_index;
  logic signed [VAL_W-1:0] value;

  modport source(output valid, action, node_index, value, input ready);
  modport sink(input valid, action, node_index, value, output ready);
endinterface

interface dfs1d_out_if import dfs1d_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_index;
  logic signed [VAL_W-1:0] node_value;
  logic                    saturated;
  logic                    last_node;

  modport source(output valid, out_index, node_value, saturated, last_node, input ready);
  modport sink(input valid, out_index, node_value, saturated, last_node, output ready);
endinterface

`default_nettype wire

/* hdl/dfs1d_cfg.sv */
// APB-style configuration register file of the diffusion step block.
// Depends on dfs1d_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module dfs1d_cfg import dfs1d_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  cfg_reg_t reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = cfg_reg_t'(paddr[CFG_AW-1:2]);
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_NUM_NODES:   cfg_nxt.num_nodes   = pwdata[NUM_W-1:0];
        REG_DIFF_RATIO:  cfg_nxt.diff_ratio  = pwdata[RAT_W-1:0];
        REG_STEP_TIME:   cfg_nxt.step_time   = pwdata[RAT_W-1:0];
        REG_FIXED_MODE:  cfg_nxt.fixed_mode  = pwdata[0];
        REG_FIXED_NODE:  cfg_nxt.fixed_node  = pwdata[IDX_W-1:0];
        REG_FIXED_VALUE: cfg_nxt.fixed_value = pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_nodes   <= NUM_W'(2);
      cfg_r.diff_ratio  <= '0;
      cfg_r.step_time   <= '0;
      cfg_r.fixed_mode  <= 1'b0;
      cfg_r.fixed_node  <= '0;
      cfg_r.fixed_value <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_NUM_NODES:   prdata = CFG_DW'(cfg_r.num_nodes);
      REG_DIFF_RATIO:  prdata = CFG_DW'(cfg_r.diff_ratio);
      REG_STEP_TIME:   prdata = CFG_DW'(cfg_r.step_time);
      REG_FIXED_MODE:  prdata = CFG_DW'(cfg_r.fixed_mode);
      REG_FIXED_NODE:  prdata = CFG_DW'(cfg_r.fixed_node);
      REG_FIXED_VALUE: prdata = CFG_DW'(cfg_r.fixed_value);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/dfs1d_ctrl.sv */
// Controller of the diffusion step block: sequences the clearing pass and
// each item through the datapath. Depends on dfs1d_pkg.
`default_nettype none

module dfs1d_ctrl import dfs1d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  output cmd_t       cmd,
  input  sts_t       sts
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          priority if (in_action == ACT_LOAD) begin
            state_nxt = ST_LOAD;
          end else if (in_action == ACT_READ) begin
            state_nxt = ST_RD_IDX;
          end else if (in_action == ACT_STEP) begin
            state_nxt = ST_SETUP;
          end else begin
            // Unused action code: the item is taken and dropped.
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_RD_IDX: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        if (sts.out_free) begin
          cmd.emit_read = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_RD_C;
      end
      ST_RD_C: begin
        cmd.rd_c  = 1'b1;
        state_nxt = ST_RD_R;
      end
      ST_RD_R: begin
        cmd.rd_r  = 1'b1;
        state_nxt = ST_LAP;
      end
      ST_LAP: begin
        cmd.lap   = 1'b1;
        state_nxt = ST_MUL_LAP;
      end
      ST_MUL_LAP: begin
        cmd.mul_lap = 1'b1;
        state_nxt   = ST_MUL_SRC;
      end
      ST_MUL_SRC: begin
        cmd.mul_src = 1'b1;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one datapath command in one cycle");
`endif

endmodule

`default_nettype wire

/* hdl/dfs1d_dp.sv */
// Datapath of the diffusion step block: node memory, sweep registers, shared
// multiplier, saturating sum and the result register. Depends on dfs1d_pkg.
`default_nettype none

module dfs1d_dp import dfs1d_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [IDX_W-1:0]        in_node_index,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_index,
  output logic signed [VAL_W-1:0] node_value,
  output logic                    saturated,
  output logic                    last_node
);

  localparam int AW    = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int KW    = (CNT_W > NUM_W) ? CNT_W : NUM_W;
  localparam int LAP_W = VAL_W + 2;
  localparam int PL_W  = LAP_W + RAT_W;
  localparam int PS_W  = VAL_W + RAT_W;
  localparam int MUL_W = LAP_W + RAT_W + 1;
  localparam int SUM_W = VAL_W + 10;

  logic signed [VAL_W-1:0] mem [MAX_NODES];
  logic signed [VAL_W-1:0] mem_q;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic                    mem_re;
  logic [AW-1:0]           mem_raddr;

  logic [AW-1:0]           clr_cnt_r;
  logic [IDX_W-1:0]        idx_r;
  logic signed [VAL_W-1:0] val_r;
  logic [AW-1:0]           sweep_pos_r;
  logic signed [VAL_W-1:0] left_old_r;
  logic [AW-1:0]           pos_r;
  logic                    first_r;
  logic                    last_r;
  logic signed [VAL_W-1:0] c_r;
  logic signed [LAP_W-1:0] lap_r;
  logic signed [PL_W-1:0]  plap_r;
  logic signed [PS_W-1:0]  psrc_r;
  logic signed [VAL_W-1:0] upd_r;
  logic                    sat_r;

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_index_r;
  logic signed [VAL_W-1:0] node_value_r;
  logic                    saturated_r;
  logic                    last_node_r;

  logic [KW-1:0]           num_k;
  logic [KW-1:0]           n_k;
  logic [AW-1:0]           pos_sel;
  logic                    idx_ok;
  logic                    force_en;

  logic signed [LAP_W-1:0] c_x;
  logic signed [LAP_W-1:0] a_x;
  logic signed [LAP_W-1:0] b_x;
  logic signed [LAP_W-1:0] lap_nxt;
  logic signed [LAP_W-1:0] mul_a;
  logic signed [RAT_W:0]   mul_b;
  logic signed [MUL_W-1:0] prod;
  logic signed [SUM_W-1:0] sum;
  logic signed [VAL_W-1:0] upd_nxt;
  logic                    sat_nxt;

  // Node count clamped to the legal range, and the sweep position restarted
  // when the count was lowered under it.
  always_comb begin
    num_k = KW'(cfg.num_nodes);
    if (num_k < KW'(2)) begin
      n_k = KW'(2);
    end else if (num_k > KW'(MAX_NODES)) begin
      n_k = KW'(MAX_NODES);
    end else begin
      n_k = num_k;
    end
    pos_sel  = (KW'(sweep_pos_r) >= n_k) ? '0 : sweep_pos_r;
    idx_ok   = KW'(idx_r) < KW'(MAX_NODES);
    force_en = (pos_sel == '0) && cfg.fixed_mode && (KW'(cfg.fixed_node) < n_k);
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = upd_r;
    priority if (cmd.clr_wr) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else if (cmd.setup) begin
      mem_we    = force_en;
      mem_waddr = AW'(cfg.fixed_node);
      mem_wdata = cfg.fixed_value;
    end else if (cmd.load_wr) begin
      mem_we    = idx_ok;
      mem_waddr = AW'(idx_r);
      mem_wdata = val_r;
    end else if (cmd.emit_step) begin
      mem_we    = 1'b1;
    end else begin
      mem_we    = 1'b0;
    end
  end

  always_comb begin
    mem_re    = cmd.rd_idx | cmd.rd_c | cmd.rd_r;
    mem_raddr = pos_r;
    priority if (cmd.rd_idx) begin
      mem_raddr = AW'(idx_r);
    end else if (cmd.rd_r) begin
      mem_raddr = pos_r + AW'(1);
    end else begin
      mem_raddr = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // Laplacian with the old left neighbor; end nodes mirror their one neighbor.
  always_comb begin
    c_x = LAP_W'(c_r);
    priority if (first_r) begin
      a_x = LAP_W'(mem_q);
      b_x = LAP_W'(mem_q);
    end else if (last_r) begin
      a_x = LAP_W'(left_old_r);
      b_x = LAP_W'(left_old_r);
    end else begin
      a_x = LAP_W'(left_old_r);
      b_x = LAP_W'(mem_q);
    end
    lap_nxt = (c_x <<< 1) - a_x - b_x;
  end

  // One multiplier serves both products.
  always_comb begin
    if (cmd.mul_lap) begin
      mul_a = lap_r;
      mul_b = {1'b0, cfg.diff_ratio};
    end else begin
      mul_a = LAP_W'(val_r);
      mul_b = {1'b0, cfg.step_time};
    end
    prod = MUL_W'(mul_a) * MUL_W'(mul_b);
  end

  // Arithmetic shifts floor toward minus infinity.
  always_comb begin
    sum = SUM_W'(c_r) - SUM_W'(plap_r >>> 16) + SUM_W'(psrc_r >>> 8);
    if (sum > SUM_W'(VAL_MAX)) begin
      upd_nxt = VAL_MAX;
      sat_nxt = 1'b1;
    end else if (sum < SUM_W'(VAL_MIN)) begin
      upd_nxt = VAL_MIN;
      sat_nxt = 1'b1;
    end else begin
      upd_nxt = sum[VAL_W-1:0];
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= in_node_index;
      val_r <= in_value;
    end
    if (cmd.setup) begin
      pos_r   <= pos_sel;
      first_r <= (pos_sel == '0);
      last_r  <= (KW'(pos_sel) == n_k - KW'(1));
    end
    if (cmd.rd_r) begin
      c_r <= mem_q;
    end
    if (cmd.lap) begin
      lap_r <= lap_nxt;
    end
    if (cmd.mul_lap) begin
      plap_r <= prod[PL_W-1:0];
    end
    if (cmd.mul_src) begin
      psrc_r <= prod[PS_W-1:0];
    end
    if (cmd.sum) begin
      upd_r <= upd_nxt;
      sat_r <= sat_nxt;
    end
    if (cmd.emit_read) begin
      out_index_r  <= idx_r;
      node_value_r <= idx_ok ? mem_q : '0;
      saturated_r  <= 1'b0;
      last_node_r  <= 1'b0;
    end else if (cmd.emit_step) begin
      out_index_r  <= IDX_W'(pos_r);
      node_value_r <= upd_r;
      saturated_r  <= sat_r;
      last_node_r  <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      sweep_pos_r <= '0;
      left_old_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.emit_step) begin
        left_old_r  <= c_r;
        sweep_pos_r <= last_r ? '0 : pos_r + AW'(1);
      end
      if (cmd.emit_read || cmd.emit_step) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.clr_done = (clr_cnt_r == AW'(MAX_NODES - 1));

  assign out_valid  = out_valid_r;
  assign out_index  = out_index_r;
  assign node_value = node_value_r;
  assign saturated  = saturated_r;
  assign last_node  = last_node_r;

`ifndef SYNTH
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_read || cmd.emit_step) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while still held");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && saturated_r) |-> ((node_value_r == VAL_MAX) || (node_value_r == VAL_MIN)))
    else $error("saturated flag without a clamped value");

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_step |-> (KW'(pos_r) < n_k))
    else $error("sweep position beyond the active node count");
`endif

endmodule

`default_nettype wire

/* hdl/diffusion_1d_explicit_step.sv */
// Top level of the 1-D explicit diffusion step block (FTCS on a lumped-mass grid).
// Depends on dfs1d_pkg, dfs1d_ifs, dfs1d_cfg, dfs1d_ctrl and dfs1d_dp.
//
//   channel   direction  ports                                  payload
//   in_ch     sink       valid / ready                          action, node_index, value
//   out_ch    source     valid / ready                          out_index, node_value,
//                                                               saturated, last_node
//   config    slave      psel, penable, pwrite, paddr, pwdata   six registers at 4*i
//
// After reset the node memory is cleared one entry a cycle, and no item is taken
// until that pass ends; configuration writes are taken during that pass.
// A load item writes one entry and a read item reads one and emits it; a step item
// runs setup, node read, right neighbor read, Laplacian, r*lap, dt*src, sum, emit
// in that order, as set by the single read port and the one shared multiplier.
// A result sits in an output register until taken; a load item can be accepted
// while it waits, while a read or step item holds in its last cycle until the
// output register is free.
`default_nettype none

module diffusion_1d_explicit_step import dfs1d_pkg::*; #(
  parameter int MAX_NODES = DEF_MAX_NODES
) (
  input  logic              clk,
  input  logic              rst_n,
  dfs1d_in_if.sink          in_ch,
  dfs1d_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  // Configuration as one struct; the user is to change it only while the block is idle, unenforced.
  cfg_t cfg;
  // Commands from the controller and status back from the datapath.
  cmd_t cmd;
  sts_t sts;

  dfs1d_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The controller accepts items only in its idle state and walks each item
  // through the datapath one step per cycle; an emit waits for a free output.
  dfs1d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // The datapath keeps the node memory, the sweep position, the old left
  // neighbor and the result register that drives the output channel.
  dfs1d_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .in_node_index (in_ch.node_index),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_index     (out_ch.out_index),
    .node_value    (out_ch.node_value),
    .saturated     (out_ch.saturated),
    .last_node     (out_ch.last_node)
  );

endmodule

`default_nettype wire
